FILE: sv/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants of the strided prefix scan unit: operation
// codes, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package sps_pkg;

  // default sizes
  localparam int unsigned DataWidthDefault = 32;
  localparam int unsigned MaxBlockDefault  = 64;

  // port and register widths
  localparam int unsigned ElemW    = 32;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DimW     = 7;

  // front-to-back queue depth
  localparam int unsigned QueueDepth = 2;

  // scan operations
  typedef enum logic [1:0] {
    OP_SUM  = 2'd0,
    OP_PROD = 2'd1,
    OP_MIN  = 2'd2,
    OP_MAX  = 2'd3
  } sps_op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_OPERATION   = 3'd0,
    REG_REVERSE     = 3'd1,
    REG_INCLUSIVE   = 3'd2,
    REG_SIGNED      = 3'd3,
    REG_SCAN_LENGTH = 3'd4,
    REG_LANE_STRIDE = 3'd5
  } sps_reg_e;

  // configuration seen by the back end, block dimensions already clamped
  typedef struct packed {
    sps_op_e         op;
    logic            reverse;
    logic            inclusive;
    logic            is_signed;
    logic [DimW-1:0] len;
    logic [DimW-1:0] str;
  } sps_cfg_t;

endpackage

FILE: sv/sps_ram.sv
// ----------------------------------------------------------------------------
// sps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/sps_queue.sv
// ----------------------------------------------------------------------------
// sps_queue
// Short register FIFO between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module sps_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = sps_pkg::QueueDepth,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/sps_front.sv
// ----------------------------------------------------------------------------
// sps_front
// Configuration registers, block dimension clamping and the position
// counters that tag every accepted element with its lane and step.
// ----------------------------------------------------------------------------
module sps_front #(
  parameter int unsigned DATA_WIDTH = sps_pkg::DataWidthDefault,
  parameter int unsigned MAX_BLOCK  = sps_pkg::MaxBlockDefault,
  localparam int unsigned IdxW  = $clog2(MAX_BLOCK),
  localparam int unsigned ItemW = DATA_WIDTH + 2 * IdxW + 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sps_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sps_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sps_pkg::ElemW-1:0]      element_value_i,
  output logic                           push_o,
  output logic [ItemW-1:0]               item_o,
  input  logic                           full_i,
  output sps_pkg::sps_cfg_t              cfg_o
);
  import sps_pkg::*;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] x;
    logic [IdxW-1:0]       pos;
    logic [IdxW-1:0]       lane;
    logic                  first;
    logic                  last;
  } item_t;

  sps_op_e         op_q;
  logic            reverse_q, inclusive_q, signed_q;
  logic [DimW-1:0] len_raw_q, str_raw_q;
  logic            cfg_hit;

  logic [DimW-1:0] quot_tbl [MAX_BLOCK];
  logic [DimW-1:0] len_eff, str_one, str_eff, quot;

  logic [IdxW-1:0] pos_q, pos_d, lane_q, lane_d, step_q, step_d;
  logic            accept, lane_end, step_end, last;
  item_t           item;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_SUM;
      reverse_q   <= 1'b0;
      inclusive_q <= 1'b1;
      signed_q    <= 1'b1;
      len_raw_q   <= DimW'(1);
      str_raw_q   <= DimW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_OPERATION:   op_q        <= sps_op_e'(cfg_data_i[1:0]);
        REG_REVERSE:     reverse_q   <= cfg_data_i[0];
        REG_INCLUSIVE:   inclusive_q <= cfg_data_i[0];
        REG_SIGNED:      signed_q    <= cfg_data_i[0];
        REG_SCAN_LENGTH: len_raw_q   <= cfg_data_i[DimW-1:0];
        REG_LANE_STRIDE: str_raw_q   <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  // a write to a known register restarts the block
  always_comb begin
    case (cfg_index_i)
      REG_OPERATION, REG_REVERSE, REG_INCLUSIVE, REG_SIGNED,
      REG_SCAN_LENGTH, REG_LANE_STRIDE: cfg_hit = cfg_we_i;
      default:                          cfg_hit = 1'b0;
    endcase
  end

  // largest stride that still fits a block, per length
  for (genvar g = 0; g < MAX_BLOCK; g++) begin : g_quot
    localparam int unsigned Quot = MAX_BLOCK / (g + 1);
    assign quot_tbl[g] = DimW'(Quot);
  end

  // clamp block dimensions
  always_comb begin
    if (len_raw_q == '0) begin
      len_eff = DimW'(1);
    end else if (len_raw_q > DimW'(MAX_BLOCK)) begin
      len_eff = DimW'(MAX_BLOCK);
    end else begin
      len_eff = len_raw_q;
    end
    quot    = quot_tbl[IdxW'(len_eff - DimW'(1))];
    str_one = (str_raw_q == '0) ? DimW'(1) : str_raw_q;
    str_eff = (str_one > quot) ? quot : str_one;
  end

  assign cfg_o.op        = op_q;
  assign cfg_o.reverse   = reverse_q;
  assign cfg_o.inclusive = inclusive_q;
  assign cfg_o.is_signed = signed_q;
  assign cfg_o.len       = len_eff;
  assign cfg_o.str       = str_eff;

  // classify the incoming element
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign lane_end   = (lane_q == IdxW'(str_eff - DimW'(1)));
  assign step_end   = (step_q == IdxW'(len_eff - DimW'(1)));
  assign last       = lane_end && step_end;

  assign item.x     = DATA_WIDTH'(element_value_i);
  assign item.pos   = pos_q;
  assign item.lane  = lane_q;
  assign item.first = (step_q == '0);
  assign item.last  = last;
  assign item_o     = item;
  assign push_o     = accept;

  // position, lane and step counters
  always_comb begin
    pos_d  = pos_q;
    lane_d = lane_q;
    step_d = step_q;
    if (cfg_hit || (accept && last)) begin
      pos_d  = '0;
      lane_d = '0;
      step_d = '0;
    end else if (accept) begin
      pos_d = pos_q + 1'b1;
      if (lane_end) begin
        lane_d = '0;
        step_d = step_q + 1'b1;
      end else begin
        lane_d = lane_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      lane_q <= '0;
      step_q <= '0;
    end else begin
      pos_q  <= pos_d;
      lane_q <= lane_d;
      step_q <= step_d;
    end
  end

  // counter invariants
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    DimW'(lane_q) < str_eff)
    else $error("lane counter beyond stride");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    DimW'(step_q) < len_eff)
    else $error("step counter beyond scan length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) == ((lane_q == '0) && (step_q == '0)))
    else $error("position out of step with lane and step counters");

endmodule

FILE: sv/sps_back.sv
// ----------------------------------------------------------------------------
// sps_back
// Scan engine: lane accumulator and block buffer memories, the shared
// combine unit, the reverse block sequencer and the output register.
// ----------------------------------------------------------------------------
module sps_back #(
  parameter int unsigned DATA_WIDTH = sps_pkg::DataWidthDefault,
  parameter int unsigned MAX_BLOCK  = sps_pkg::MaxBlockDefault,
  localparam int unsigned IdxW  = $clog2(MAX_BLOCK),
  localparam int unsigned ItemW = DATA_WIDTH + 2 * IdxW + 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sps_pkg::sps_cfg_t         cfg_i,
  input  logic                      item_valid_i,
  output logic                      pop_o,
  input  logic [ItemW-1:0]          item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sps_pkg::ElemW-1:0] scan_value_o,
  output logic                      block_last_o
);
  import sps_pkg::*;

  localparam int unsigned HalfW = (DATA_WIDTH + 1) / 2;
  localparam int unsigned HiW   = DATA_WIDTH - HalfW;
  localparam int unsigned MulW  = (DATA_WIDTH < ElemW) ? DATA_WIDTH : ElemW;
  localparam int unsigned PloW  = HalfW + MulW;
  localparam int unsigned PhiW  = HiW + MulW;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] x;
    logic [IdxW-1:0]       pos;
    logic [IdxW-1:0]       lane;
    logic                  first;
    logic                  last;
  } item_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_FW_RD  = 10'b0000000010,
    S_FW_CMB = 10'b0000000100,
    S_FW_WB  = 10'b0000001000,
    S_RV_RD  = 10'b0000010000,
    S_RV_OP  = 10'b0000100000,
    S_RV_CMB = 10'b0001000000,
    S_RV_WB  = 10'b0010000000,
    S_EM_RD  = 10'b0100000000,
    S_EM_OUT = 10'b1000000000
  } back_state_e;

  back_state_e state_q, state_d;
  item_t       head, cur_q;

  logic [DATA_WIDTH-1:0] opa_q, opa_d, opb_q, opb_d;
  logic [PloW-1:0]       plo_q;
  logic [PhiW-1:0]       phi_q;
  logic [DATA_WIDTH-1:0] ident, prod, cmb, res, opa_key, opb_key;
  logic                  a_lt_b, b_lt_a, is_prod;

  logic [IdxW-1:0] idx_q, idx_d, base_q, base_d, k_q, k_d, step_q, step_d, p_q, p_d;
  logic [IdxW-1:0] rv_base;

  logic                  acc_re, acc_we;
  logic [DATA_WIDTH-1:0] acc_rdata;
  logic                  buf_re, buf_we;
  logic [IdxW-1:0]       buf_raddr, buf_waddr;
  logic [DATA_WIDTH-1:0] buf_wdata, buf_rdata;

  logic                  out_valid_q, out_free, out_load, out_last, block_last_q;
  logic [DATA_WIDTH-1:0] out_data;
  logic [ElemW-1:0]      scan_q;

  assign head    = item_t'(item_i);
  assign is_prod = (cfg_i.op == OP_PROD);

  // identity of the operation
  always_comb begin
    case (cfg_i.op)
      OP_SUM:  ident = '0;
      OP_PROD: ident = DATA_WIDTH'(1);
      OP_MIN:  ident = cfg_i.is_signed ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : '1;
      OP_MAX:  ident = cfg_i.is_signed ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : '0;
      default: ident = '0;
    endcase
  end

  // combine unit: product from registered partial products
  assign prod = DATA_WIDTH'(plo_q) + DATA_WIDTH'({phi_q, {HalfW{1'b0}}});
  assign opa_key = opa_q ^ {cfg_i.is_signed, {(DATA_WIDTH-1){1'b0}}};
  assign opb_key = opb_q ^ {cfg_i.is_signed, {(DATA_WIDTH-1){1'b0}}};
  assign a_lt_b  = (opa_key < opb_key);
  assign b_lt_a  = (opb_key < opa_key);

  always_comb begin
    case (cfg_i.op)
      OP_SUM:  cmb = opa_q + opb_q;
      OP_PROD: cmb = prod;
      OP_MIN:  cmb = b_lt_a ? opb_q : opa_q;
      OP_MAX:  cmb = a_lt_b ? opb_q : opa_q;
      default: cmb = opa_q;
    endcase
  end

  // exclusive results show the running value before this element
  assign res = cfg_i.inclusive ? cmb : opa_q;

  assign rv_base  = head.pos - IdxW'(cfg_i.str - DimW'(1));
  assign out_free = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d   = state_q;
    opa_d     = opa_q;
    opb_d     = opb_q;
    idx_d     = idx_q;
    base_d    = base_q;
    k_d       = k_q;
    step_d    = step_q;
    p_d       = p_q;
    pop_o     = 1'b0;
    acc_re    = 1'b0;
    acc_we    = 1'b0;
    buf_re    = 1'b0;
    buf_we    = 1'b0;
    buf_raddr = idx_q;
    buf_waddr = idx_q;
    buf_wdata = res;
    out_load  = 1'b0;
    out_data  = res;
    out_last  = cur_q.last;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          pop_o = 1'b1;
          if (cfg_i.reverse) begin
            buf_we    = 1'b1;
            buf_waddr = head.pos;
            buf_wdata = head.x;
            if (head.last) begin
              idx_d   = rv_base;
              base_d  = rv_base;
              k_d     = '0;
              step_d  = IdxW'(cfg_i.len - DimW'(1));
              opa_d   = ident;
              state_d = S_RV_RD;
            end
          end else begin
            acc_re  = 1'b1;
            state_d = S_FW_RD;
          end
        end
      end
      // forward: running value of the lane against the new element
      S_FW_RD: begin
        opa_d   = cur_q.first ? ident : acc_rdata;
        opb_d   = cur_q.x;
        state_d = is_prod ? S_FW_CMB : S_FW_WB;
      end
      S_FW_CMB: state_d = S_FW_WB;
      S_FW_WB: begin
        if (out_free) begin
          out_load = 1'b1;
          acc_we   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      // reverse: walk each lane from its end, results written in place
      S_RV_RD: begin
        buf_re  = 1'b1;
        state_d = S_RV_OP;
      end
      S_RV_OP: begin
        opb_d   = buf_rdata;
        state_d = is_prod ? S_RV_CMB : S_RV_WB;
      end
      S_RV_CMB: state_d = S_RV_WB;
      S_RV_WB: begin
        buf_we = 1'b1;
        opa_d  = cmb;
        if (step_q == '0) begin
          if (k_q == IdxW'(cfg_i.str - DimW'(1))) begin
            p_d     = '0;
            state_d = S_EM_RD;
          end else begin
            k_d     = k_q + 1'b1;
            base_d  = base_q + 1'b1;
            idx_d   = base_q + 1'b1;
            step_d  = IdxW'(cfg_i.len - DimW'(1));
            opa_d   = ident;
            state_d = S_RV_RD;
          end
        end else begin
          idx_d   = idx_q - IdxW'(cfg_i.str);
          step_d  = step_q - 1'b1;
          state_d = S_RV_RD;
        end
      end
      // reverse: emit the block in array order
      S_EM_RD: begin
        buf_re    = 1'b1;
        buf_raddr = p_q;
        state_d   = S_EM_OUT;
      end
      S_EM_OUT: begin
        out_data = buf_rdata;
        out_last = (p_q == cur_q.pos);
        if (out_free) begin
          out_load = 1'b1;
          if (out_last) begin
            state_d = S_IDLE;
          end else begin
            p_d     = p_q + 1'b1;
            state_d = S_EM_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      base_q      <= '0;
      k_q         <= '0;
      step_q      <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      base_q  <= base_d;
      k_q     <= k_d;
      step_q  <= step_d;
      p_q     <= p_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    opa_q <= opa_d;
    opb_q <= opb_d;
    if (pop_o) begin
      cur_q <= head;
    end
    if (state_q == S_FW_CMB || state_q == S_RV_CMB) begin
      plo_q <= PloW'(opa_q[HalfW-1:0]) * PloW'(opb_q[MulW-1:0]);
      phi_q <= PhiW'(opa_q[DATA_WIDTH-1:HalfW]) * PhiW'(opb_q[MulW-1:0]);
    end
    if (out_load) begin
      scan_q       <= ElemW'(out_data);
      block_last_q <= out_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scan_value_o = scan_q;
  assign block_last_o = block_last_q;

  // per-lane running values
  sps_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_BLOCK)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (cur_q.lane),
    .wdata_i (cmb),
    .re_i    (acc_re),
    .raddr_i (head.lane),
    .rdata_o (acc_rdata)
  );

  // reverse block buffer, overwritten in place with results
  sps_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_BLOCK)
  ) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // reverse walk stays inside the buffered block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RV_RD) |-> (idx_q <= cur_q.pos))
    else $error("reverse walk left the block");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RV_RD) |-> (DimW'(step_q) < cfg_i.len))
    else $error("reverse step beyond scan length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RV_WB) |-> (DimW'(k_q) < cfg_i.str))
    else $error("reverse lane beyond stride");

endmodule

FILE: sv/strided_prefix_scan_unit.sv
// ----------------------------------------------------------------------------
// strided_prefix_scan_unit
// Inclusive or exclusive prefix scan (sum, product, min, max) along the
// scanned axis of row-major blocks, one accumulator per interleaved lane.
// ----------------------------------------------------------------------------
// In forward mode every element gives one result: the scan engine reads the
// lane accumulator RAM, combines and writes back, the product adding one
// stage for its registered partial products, and it finishes one element
// before it takes the next. In reverse mode each element is stored in the
// block buffer RAM; the block's last also starts a backward walk of the
// buffer RAM with the same read, combine and write-back steps per element,
// followed by the emission of the block in array order, one buffer read per
// result. A two-entry queue sits between the input classifier and the scan
// engine, and a result register sits at the output, so elements keep being
// accepted until the queue fills while a result waits to be taken.
// Configuration writes restart the block and are meant for idle periods only.
module strided_prefix_scan_unit #(
  parameter int unsigned DATA_WIDTH = sps_pkg::DataWidthDefault,
  parameter int unsigned MAX_BLOCK  = sps_pkg::MaxBlockDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sps_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sps_pkg::ElemW-1:0]     element_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sps_pkg::ElemW-1:0]     scan_value_o,
  output logic                          block_last_o
);
  import sps_pkg::*;

  localparam int unsigned IdxW  = $clog2(MAX_BLOCK);
  localparam int unsigned ItemW = DATA_WIDTH + 2 * IdxW + 2;

  sps_cfg_t         cfg;
  logic             push, full, q_valid, pop;
  logic [ItemW-1:0] push_item, head_item;

  // input classification and configuration
  sps_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .element_value_i (element_value_i),
    .push_o          (push),
    .item_o          (push_item),
    .full_i          (full),
    .cfg_o           (cfg)
  );

  // decoupling queue
  sps_queue #(
    .WIDTH (ItemW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_item)
  );

  // scan engine
  sps_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (q_valid),
    .pop_o        (pop),
    .item_i       (head_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .scan_value_o (scan_value_o),
    .block_last_o (block_last_o)
  );

endmodule
